[rtl/core/kmc_network_event_select_unit_assert.svh]
// assertion helpers for the event select unit
`ifndef KMC_NETWORK_EVENT_SELECT_UNIT_ASSERT_SVH
`define KMC_NETWORK_EVENT_SELECT_UNIT_ASSERT_SVH

`ifndef SYNTH
// condition holds at every edge out of reset
`define KMCES_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("kmces: invariant violated");
// consequent holds in the same cycle
`define KMCES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmces: implication violated");
// consequent holds in the next cycle
`define KMCES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmces: next-cycle check violated");
`else
`define KMCES_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define KMCES_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KMCES_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/kmces_pkg.sv]
package kmces_pkg;

    // field widths
    localparam int RATE_W      = 24;
    localparam int EVENT_W     = 33;
    localparam int FRAC_W      = 32;
    localparam int TARGET_W    = 32;
    localparam int KIND_W      = 2;
    localparam int ACTOR_W     = 10;
    localparam int SLOT_W      = 6;
    localparam int USERS_W     = 11;
    localparam int COUNT_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    // rates reset to 1.0 in 8.16
    localparam logic [RATE_W-1:0] RATE_RESET = 24'h01_0000;

    localparam int USER_LIMIT_DEF = 1024;
    localparam int LIST_LIMIT_DEF = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_FOLLOW = 2'd1,
        KIND_TWEET  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_USERS_FULL = 2'd1,
        ST_LIST_FULL  = 2'd2
    } t_status;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ADD_RATE      = 2'd0,
        CFG_FOLLOW_RATE   = 2'd1,
        CFG_TWEET_RATE    = 2'd2,
        CFG_INITIAL_USERS = 2'd3
    } t_cfg_index;

endpackage

[rtl/core/kmces_serial_mul.sv]
module kmces_serial_mul #(
    parameter int A_W = 24,
    parameter int B_W = 11
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [A_W-1:0] i_a,
    input  logic [B_W-1:0] i_b,
    output logic           o_done,
    output logic [A_W-1:0] o_hi,
    output logic [B_W-1:0] o_lo
);

    localparam int CNT_W = $clog2(B_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi;
    logic [B_W-1:0]   r_lo;   // multiplier bits shift out, product bits shift in
    logic [A_W:0]     n_sum;

    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : {(A_W + 1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_hi   <= '0;
                r_lo   <= i_b;
            end else if (r_busy) begin
                r_hi  <= n_sum[A_W:1];
                r_lo  <= {n_sum[0], r_lo[B_W-1:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;

endmodule

[rtl/core/kmces_serial_div.sv]
module kmces_serial_div #(
    parameter int Q_W = 11
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [kmces_pkg::RATE_W+Q_W-1:0]  i_num,
    input  logic [kmces_pkg::RATE_W-1:0]      i_den,
    output logic                              o_done,
    output logic [Q_W-1:0]                    o_quot
);
    import kmces_pkg::*;

    localparam int CNT_W = $clog2(Q_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RATE_W-1:0] r_den;
    logic [RATE_W-1:0] r_rem;
    logic [Q_W-1:0]    r_sh;   // dividend low bits out, quotient bits in
    logic [RATE_W:0]   n_trial;
    logic [RATE_W:0]   n_diff;
    logic              n_ge;

    // restoring step, dividend is below den * 2^Q_W
    always_comb begin
        n_trial = {r_rem, r_sh[Q_W-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_den;
                r_rem  <= i_num[RATE_W+Q_W-1:Q_W];
                r_sh   <= i_num[Q_W-1:0];
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[RATE_W-1:0] : n_trial[RATE_W-1:0];
                r_sh  <= {r_sh[Q_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sh;

endmodule

[rtl/core/kmces_list_mem.sv]
module kmces_list_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    output logic              o_clearing
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    // zeroing sweep, one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

[rtl/core/kmc_network_event_select_unit.sv]
// event selection for a growing follow network, one draw in, one event out
//
// input channel: i_in_valid / o_in_stall carry event_draw and target_draw; a
// transaction completes on a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry the chosen event, its acting
// user, the stored follow target and slot, the running totals and a status
// config channel: i_cfg_valid / o_cfg_ready (always ready) writes add, follow,
// tweet rate (8.16) and initial users; writing initial users loads the count
//
// one item at a time; the next item is taken in the cycle after the result is
// registered; the work is, in order, the serial rate multiplies, the 33-step
// draw multiply and, for a follow or tweet, the serial quotient for the user
//
// reset: rates 1.0, no users, totals zero; the per-user list lengths are then
// zeroed by a sweep over all USER_LIMIT entries during which input stays stalled
// (config writes still go through)
// a stalled result sits in the output register while the next item is taken
// and worked on; that item waits at the end until the register frees up
module kmc_network_event_select_unit #(
    parameter int USER_LIMIT = kmces_pkg::USER_LIMIT_DEF,
    parameter int LIST_LIMIT = kmces_pkg::LIST_LIMIT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item in
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [kmces_pkg::EVENT_W-1:0]       i_event_draw,
    input  logic [kmces_pkg::TARGET_W-1:0]      i_target_draw,
    // result out
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [kmces_pkg::KIND_W-1:0]        o_event_kind,
    output logic [kmces_pkg::ACTOR_W-1:0]       o_acting_user,
    output logic [kmces_pkg::ACTOR_W-1:0]       o_followed_user,
    output logic [kmces_pkg::SLOT_W-1:0]        o_list_slot,
    output logic [kmces_pkg::USERS_W-1:0]       o_user_total,
    output logic [kmces_pkg::COUNT_W-1:0]       o_follow_total,
    output logic [kmces_pkg::COUNT_W-1:0]       o_tweet_total,
    output logic [kmces_pkg::STATUS_W-1:0]      o_status,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kmces_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [kmces_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import kmces_pkg::*;

    `include "kmc_network_event_select_unit_assert.svh"

    localparam int CW = $clog2(USER_LIMIT + 1);  // user count
    localparam int UW = $clog2(USER_LIMIT);      // user index
    localparam int LW = $clog2(LIST_LIMIT + 1);  // list length
    localparam int NW = RATE_W + CW;             // users * rate, band offset
    localparam int BW = NW + 2;                  // band edges

    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE,
        S_PMUL,
        S_SEL,
        S_DIFF,
        S_DIV,
        S_READ,
        S_LIST,
        S_DONE
    } t_state;

    t_state              r_state;

    // configuration and running state
    logic [RATE_W-1:0]   r_add_rate;
    logic [RATE_W-1:0]   r_follow_rate;
    logic [RATE_W-1:0]   r_tweet_rate;
    logic [CW-1:0]       r_user_count;
    logic [COUNT_W-1:0]  r_follows;
    logic [COUNT_W-1:0]  r_tweets;

    // per-item work registers
    logic [EVENT_W-1:0]  r_event;
    logic [BW-1:0]       r_b2;
    logic [BW-1:0]       r_bound;
    logic [RATE_W-1:0]   r_rate;
    t_kind               r_kind;
    t_status             r_status;
    logic [UW-1:0]       r_actor;
    logic [CW-1:0]       r_target;
    logic [LW-1:0]       r_slot;

    // output register
    logic                r_out_valid;
    t_kind               r_out_kind;
    logic [ACTOR_W-1:0]  r_out_actor;
    logic [ACTOR_W-1:0]  r_out_followed;
    logic [SLOT_W-1:0]   r_out_slot;
    logic [USERS_W-1:0]  r_out_users;
    logic [COUNT_W-1:0]  r_out_follows;
    logic [COUNT_W-1:0]  r_out_tweets;
    t_status             r_out_status;

    // unit hookups
    logic                accept;
    logic                rate_done;
    logic [RATE_W-1:0]   nf_hi;
    logic [CW-1:0]       nf_lo;
    logic [RATE_W-1:0]   nt_hi;
    logic [CW-1:0]       nt_lo;
    logic [CW-1:0]       tgt_hi;
    logic                p_start;
    logic                p_done;
    logic [BW-1:0]       p_hi;
    logic [EVENT_W-1:0]  p_lo;
    logic                div_start;
    logic                div_done;
    logic [CW-1:0]       quot;
    logic                rd_en;
    logic [LW-1:0]       rd_data;
    logic                wr_en;
    logic [LW-1:0]       wr_data;
    logic                clearing;

    // combinational next values
    logic [BW-1:0]       n_b2;
    logic [BW-1:0]       n_b3;
    logic [BW:0]         n_p_top;
    logic                n_lo_zero;
    logic                n_in_add;
    logic                n_in_follow;
    logic [NW-1:0]       n_diff;
    logic [CW-1:0]       n_quot;
    logic [UW-1:0]       n_actor;
    logic                n_list_full;
    logic                n_users_full;
    logic [CW-1:0]       n_user_count;
    logic [COUNT_W-1:0]  n_follow_count;
    logic [COUNT_W-1:0]  n_tweet_count;
    t_status             n_status;
    logic                n_load;
    logic [USERS_W-1:0]  n_cfg_users;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE) || clearing;
    assign accept      = i_in_valid && !o_in_stall;

    // users * follow_rate and users * tweet_rate, one user-count bit per cycle
    kmces_serial_mul #(
        .A_W (RATE_W),
        .B_W (CW)
    ) u_mul_follow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_a     (r_follow_rate),
        .i_b     (r_user_count),
        .o_done  (rate_done),
        .o_hi    (nf_hi),
        .o_lo    (nf_lo)
    );

    kmces_serial_mul #(
        .A_W (RATE_W),
        .B_W (CW)
    ) u_mul_tweet (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_a     (r_tweet_rate),
        .i_b     (r_user_count),
        .o_done  (),
        .o_hi    (nt_hi),
        .o_lo    (nt_lo)
    );

    // followed user = upper part of target_draw * users, runs alongside
    kmces_serial_mul #(
        .A_W (CW),
        .B_W (TARGET_W)
    ) u_mul_target (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_a     (r_user_count),
        .i_b     (i_target_draw),
        .o_done  (),
        .o_hi    (tgt_hi),
        .o_lo    ()
    );

    // band edges once the rate products are in
    always_comb begin
        n_b2 = BW'(r_add_rate) + BW'({nf_hi, nf_lo});
        n_b3 = n_b2 + BW'({nt_hi, nt_lo});
    end

    assign p_start = (r_state == S_RATE) && rate_done;

    // scaled draw position: event_draw * total, one draw bit per cycle
    kmces_serial_mul #(
        .A_W (BW),
        .B_W (EVENT_W)
    ) u_mul_draw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (p_start),
        .i_a     (n_b3),
        .i_b     (r_event),
        .o_done  (p_done),
        .o_hi    (p_hi),
        .o_lo    (p_lo)
    );

    // band compare against edge * 2^32: integer part, then the fraction bits
    always_comb begin
        n_p_top     = {p_hi, p_lo[FRAC_W]};
        n_lo_zero   = (p_lo[FRAC_W-1:0] == '0);
        n_in_add    = (n_p_top < (BW + 1)'(r_add_rate)) ||
                      ((n_p_top == (BW + 1)'(r_add_rate)) && n_lo_zero);
        n_in_follow = (n_p_top < {1'b0, r_b2}) ||
                      ((n_p_top == {1'b0, r_b2}) && n_lo_zero);
        // offset inside the band never exceeds users * rate
        n_diff      = NW'(n_p_top - {1'b0, r_bound});
    end

    assign div_start = (r_state == S_DIFF);

    // acting user = offset / per-user rate
    kmces_serial_div #(
        .Q_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (n_diff),
        .i_den   (r_rate),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // clamp the quotient to the last user
    always_comb begin
        n_quot = (r_rate == '0) ? '0 : quot;
        if (r_user_count == '0) begin
            n_actor = '0;
        end else if (n_quot >= r_user_count) begin
            n_actor = UW'(r_user_count - 1'b1);
        end else begin
            n_actor = UW'(n_quot);
        end
    end

    // follow list lengths; the target itself leaves on the result
    assign rd_en       = (r_state == S_READ);
    assign n_list_full = (rd_data >= LW'(LIST_LIMIT));
    assign wr_en       = (r_state == S_LIST) && !n_list_full;
    assign wr_data     = rd_data + 1'b1;

    kmces_list_mem #(
        .DEPTH  (USER_LIMIT),
        .ADDR_W (UW),
        .DATA_W (LW)
    ) u_list_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_actor),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_actor),
        .i_wr_data  (wr_data),
        .o_clearing (clearing)
    );

    // state updates at the end of an item
    always_comb begin
        n_users_full   = (r_user_count >= CW'(USER_LIMIT));
        n_user_count   = r_user_count;
        n_follow_count = r_follows;
        n_tweet_count  = r_tweets;
        case (r_kind)
            KIND_ADD: begin
                if (!n_users_full) begin
                    n_user_count = r_user_count + 1'b1;
                end
            end
            KIND_FOLLOW: begin
                if (r_follows != '1) begin
                    n_follow_count = r_follows + 1'b1;
                end
            end
            KIND_TWEET: begin
                if (r_tweets != '1) begin
                    n_tweet_count = r_tweets + 1'b1;
                end
            end
            default: ;
        endcase
        n_status = ((r_kind == KIND_ADD) && n_users_full) ? ST_USERS_FULL : r_status;
    end

    assign n_load      = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign n_cfg_users = i_cfg_data[USERS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_add_rate    <= RATE_RESET;
            r_follow_rate <= RATE_RESET;
            r_tweet_rate  <= RATE_RESET;
            r_user_count  <= '0;
            r_follows     <= '0;
            r_tweets      <= '0;
        end else begin
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // draws above one count as one
                        r_event  <= i_event_draw[FRAC_W] ?
                                    {1'b1, {FRAC_W{1'b0}}} : i_event_draw;
                        r_status <= ST_OK;
                        r_actor  <= '0;
                        r_target <= '0;
                        r_slot   <= '0;
                        r_state  <= S_RATE;
                    end
                end
                S_RATE: begin
                    if (rate_done) begin
                        r_b2    <= n_b2;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    if (p_done) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (n_in_add) begin
                        r_kind  <= KIND_ADD;
                        r_state <= S_DONE;
                    end else if (n_in_follow) begin
                        r_kind  <= KIND_FOLLOW;
                        r_bound <= BW'(r_add_rate);
                        r_rate  <= r_follow_rate;
                        r_state <= S_DIFF;
                    end else begin
                        r_kind  <= KIND_TWEET;
                        r_bound <= r_b2;
                        r_rate  <= r_tweet_rate;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_actor <= n_actor;
                        r_state <= (r_kind == KIND_FOLLOW) ? S_READ : S_DONE;
                    end
                end
                S_READ: begin
                    r_state <= S_LIST;
                end
                S_LIST: begin
                    if (n_list_full) begin
                        r_status <= ST_LIST_FULL;
                    end else begin
                        r_target <= tgt_hi;
                        r_slot   <= rd_data;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (n_load) begin
                        r_user_count   <= n_user_count;
                        r_follows      <= n_follow_count;
                        r_tweets       <= n_tweet_count;
                        r_out_kind     <= r_kind;
                        r_out_actor    <= ACTOR_W'(r_actor);
                        r_out_followed <= ACTOR_W'(r_target);
                        r_out_slot     <= SLOT_W'(r_slot);
                        r_out_users    <= USERS_W'(n_user_count);
                        r_out_follows  <= n_follow_count;
                        r_out_tweets   <= n_tweet_count;
                        r_out_status   <= n_status;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // register writes must arrive only while idle; the user is bound, the block does not enforce it
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_ADD_RATE:      r_add_rate    <= i_cfg_data[RATE_W-1:0];
                    CFG_FOLLOW_RATE:   r_follow_rate <= i_cfg_data[RATE_W-1:0];
                    CFG_TWEET_RATE:    r_tweet_rate  <= i_cfg_data[RATE_W-1:0];
                    CFG_INITIAL_USERS: begin
                        if (32'(n_cfg_users) > 32'(USER_LIMIT)) begin
                            r_user_count <= CW'(USER_LIMIT);
                        end else begin
                            r_user_count <= CW'(n_cfg_users);
                        end
                    end
                endcase
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_kind    = r_out_kind;
    assign o_acting_user   = r_out_actor;
    assign o_followed_user = r_out_followed;
    assign o_list_slot     = r_out_slot;
    assign o_user_total    = r_out_users;
    assign o_follow_total  = r_out_follows;
    assign o_tweet_total   = r_out_tweets;
    assign o_status        = r_out_status;

    // user count never passes the table size
    `KMCES_ASSERT_ALWAYS(a_users_bounded, i_clk, i_rst_n, r_user_count <= CW'(USER_LIMIT))
    // clamped actor lies inside the current population when its list is read
    `KMCES_ASSERT_IMPL(a_actor_in_range, i_clk, i_rst_n, r_state == S_READ, CW'(r_actor) < r_user_count)
    // a finished item shows up on the output
    `KMCES_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, n_load, o_out_valid)
    // a delivered follow leaves a nonzero follow total
    `KMCES_ASSERT_NEXT(a_follow_counted, i_clk, i_rst_n, n_load && (r_kind == KIND_FOLLOW), r_follows != '0)

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import kmces_pkg::*;

    // run size and limits, in cycles where not stated
    localparam int USER_LIMIT   = USER_LIMIT_DEF;
    localparam int LIST_LIMIT   = LIST_LIMIT_DEF;
    localparam int RANDOM_ITEMS = 1500;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 4000;  // reset sweep, hold-off and slow items fit many times
    localparam int DRAIN_CYCLES = 80;    // a bit more than the slowest item
    localparam int MAX_REPORTS  = 10;

    // u = 1.0 on the draw scale
    localparam logic [EVENT_W-1:0] FULL_DRAW = 33'h1_0000_0000;

    typedef struct packed {
        t_kind                kind;
        logic [ACTOR_W-1:0]   actor;
        logic [ACTOR_W-1:0]   followed;
        logic [SLOT_W-1:0]    slot;
        logic [USERS_W-1:0]   users;
        logic [COUNT_W-1:0]   follows;
        logic [COUNT_W-1:0]   tweets;
        t_status              status;
    } t_event_result;

    // directed plan: a draw to send or a full register setting
    typedef enum {ROW_DRAW, ROW_SETTINGS} t_row_op;

    typedef struct {
        t_row_op              op;
        logic [EVENT_W-1:0]   draw;
        logic [TARGET_W-1:0]  frac;
        bit                   typed;   // known holds the expected event, follow and tweet totals aside
        t_event_result        known;
        logic [RATE_W-1:0]    add;
        logic [RATE_W-1:0]    follow;
        logic [RATE_W-1:0]    tweet;
        logic [USERS_W-1:0]   users;
    } t_plan_row;

    // register mixes for the random phases
    typedef enum {MIX_ANY, MIX_LIST_FILL, MIX_CROWDED} t_profile;

    // receiver stall patterns
    typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} t_flow;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [EVENT_W-1:0]      i_event_draw = '0;
    logic [TARGET_W-1:0]     i_target_draw = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [KIND_W-1:0]       o_event_kind;
    logic [ACTOR_W-1:0]      o_acting_user;
    logic [ACTOR_W-1:0]      o_followed_user;
    logic [SLOT_W-1:0]       o_list_slot;
    logic [USERS_W-1:0]      o_user_total;
    logic [COUNT_W-1:0]      o_follow_total;
    logic [COUNT_W-1:0]      o_tweet_total;
    logic [STATUS_W-1:0]     o_status;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = CFG_ADD_RATE;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // predictor copy of registers and state
    logic [RATE_W-1:0]       rate_add;
    logic [RATE_W-1:0]       rate_follow;
    logic [RATE_W-1:0]       rate_tweet;
    logic [USERS_W-1:0]      users_now;
    logic [COUNT_W-1:0]      follows_now;
    logic [COUNT_W-1:0]      tweets_now;
    logic [6:0]              follow_count [USER_LIMIT];

    t_event_result           pending [$];   // expected events, oldest first
    t_plan_row               plan [$];
    int                      fault_count = 0;
    int                      burst_left = 0;

    kmc_network_event_select_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_event_draw    (i_event_draw),
        .i_target_draw   (i_target_draw),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_event_kind    (o_event_kind),
        .o_acting_user   (o_acting_user),
        .o_followed_user (o_followed_user),
        .o_list_slot     (o_list_slot),
        .o_user_total    (o_user_total),
        .o_follow_total  (o_follow_total),
        .o_tweet_total   (o_tweet_total),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_state();
        rate_add    = RATE_RESET;
        rate_follow = RATE_RESET;
        rate_tweet  = RATE_RESET;
        users_now   = '0;
        follows_now = '0;
        tweets_now  = '0;
        foreach (follow_count[i]) follow_count[i] = '0;
    endfunction

    // writing initial users also loads the live count, capped at the table size
    function automatic void apply_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_ADD_RATE:      rate_add = value;
            CFG_FOLLOW_RATE:   rate_follow = value;
            CFG_TWEET_RATE:    rate_tweet = value;
            CFG_INITIAL_USERS: begin
                users_now = (value[USERS_W-1:0] > USER_LIMIT) ? USERS_W'(USER_LIMIT)
                                                               : value[USERS_W-1:0];
            end
            default: ;
        endcase
    endfunction

    // user whose slice of the band holds the draw, clamped to the last user
    function automatic logic [ACTOR_W-1:0] charged_user(logic [95:0] excess,
                                                        logic [RATE_W-1:0] rate);
        logic [63:0] offset;
        logic [63:0] pick;
        offset = 64'(excess >> 32);
        pick = (rate != '0) ? offset / 64'(rate) : 64'd0;
        if (users_now == '0) return '0;
        if (pick >= 64'(users_now)) pick = 64'(users_now) - 64'd1;
        return pick[ACTOR_W-1:0];
    endfunction

    // pick add, follow or tweet from the weighted bands and update the network
    function automatic t_event_result select_event(logic [EVENT_W-1:0] draw_in,
                                                   logic [TARGET_W-1:0] frac);
        logic [EVENT_W-1:0] draw;
        logic [47:0]        n;
        logic [47:0]        band_add;
        logic [47:0]        band_follow;
        logic [47:0]        band_all;
        logic [95:0]        weight;
        logic [95:0]        add_edge;
        logic [95:0]        follow_edge;
        logic [63:0]        target;
        t_event_result      r;
        draw = (draw_in > FULL_DRAW) ? FULL_DRAW : draw_in;
        n = 48'(users_now);
        band_add = 48'(rate_add);
        band_follow = band_add + n * 48'(rate_follow);
        band_all = band_follow + n * 48'(rate_tweet);
        weight = 96'(draw) * 96'(band_all);
        add_edge = 96'(band_add) << 32;
        follow_edge = 96'(band_follow) << 32;
        r = '0;
        r.kind = KIND_ADD;
        r.status = ST_OK;
        if (weight <= add_edge) begin
            if (users_now >= USER_LIMIT) r.status = ST_USERS_FULL;
            else users_now++;
        end else if (weight <= follow_edge) begin
            r.kind = KIND_FOLLOW;
            r.actor = charged_user(weight - add_edge, rate_follow);
            if (follows_now != '1) follows_now++;
            // a full list still counts the follow but stores nothing
            if (follow_count[r.actor] >= LIST_LIMIT) begin
                r.status = ST_LIST_FULL;
            end else begin
                target = (64'(frac) * 64'(users_now)) >> 32;
                r.followed = target[ACTOR_W-1:0];
                r.slot = follow_count[r.actor][SLOT_W-1:0];
                follow_count[r.actor]++;
            end
        end else begin
            r.kind = KIND_TWEET;
            r.actor = charged_user(weight - follow_edge, rate_tweet);
            if (tweets_now != '1) tweets_now++;
        end
        r.users = users_now;
        r.follows = follows_now;
        r.tweets = tweets_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers, all entered right after a rising edge
    // ------------------------------------------------------------------

    function automatic t_plan_row draw_row(logic [EVENT_W-1:0] e, logic [TARGET_W-1:0] t);
        t_plan_row row;
        row.op = ROW_DRAW;
        row.draw = e;
        row.frac = t;
        row.typed = 1'b0;
        row.known = '0;
        row.add = '0;
        row.follow = '0;
        row.tweet = '0;
        row.users = '0;
        return row;
    endfunction

    // add and tweet rows whose outcome is plain from the rates
    function automatic t_plan_row known_row(logic [EVENT_W-1:0] e, logic [TARGET_W-1:0] t,
                                            t_kind k, logic [ACTOR_W-1:0] actor,
                                            logic [USERS_W-1:0] users, t_status st);
        t_plan_row row;
        row = draw_row(e, t);
        row.typed = 1'b1;
        row.known.kind = k;
        row.known.actor = actor;
        row.known.users = users;
        row.known.status = st;
        return row;
    endfunction

    function automatic t_plan_row settings_row(logic [RATE_W-1:0] a, logic [RATE_W-1:0] f,
                                               logic [RATE_W-1:0] tw,
                                               logic [USERS_W-1:0] u);
        t_plan_row row;
        row = draw_row('0, '0);
        row.op = ROW_SETTINGS;
        row.add = a;
        row.follow = f;
        row.tweet = tw;
        row.users = u;
        return row;
    endfunction

    // valid stays up after the transaction; caller offers again or lowers it
    task automatic offer_draw(logic [EVENT_W-1:0] e, logic [TARGET_W-1:0] t);
        i_in_valid <= 1'b1;
        i_event_draw <= e;
        i_target_draw <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // bursts of random length, gaps long enough to land anywhere in an item
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 11);
        case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(1, 4);
            2: gap = $urandom_range(5, 80);
            default: gap = $urandom_range(1, 48);
        endcase
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_register(t_cfg_index idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, value);
    endtask

    // registers change only once every result is out and no item is offered
    task automatic load_settings(logic [RATE_W-1:0] a, logic [RATE_W-1:0] f,
                                 logic [RATE_W-1:0] tw, logic [USERS_W-1:0] u);
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        write_register(CFG_ADD_RATE, a);
        write_register(CFG_FOLLOW_RATE, f);
        write_register(CFG_TWEET_RATE, tw);
        write_register(CFG_INITIAL_USERS, CFG_DATA_W'(u));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [RATE_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return RATE_W'(1);
            3: return RATE_RESET;
            default: return RATE_W'($urandom_range(0, 24'hFF_FFFF));
        endcase
    endfunction

    function automatic logic [USERS_W-1:0] pick_users();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return USERS_W'(USER_LIMIT);
            2: return USERS_W'($urandom_range(1, 4));
            default: return USERS_W'($urandom_range(0, 64));
        endcase
    endfunction

    // mostly draws in (0,1), with zero, exactly one and above one mixed in
    function automatic logic [EVENT_W-1:0] random_draw();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return FULL_DRAW;
            2: return {1'b1, 32'($urandom())};
            3: return EVENT_W'($urandom_range(1, 255));
            default: return {1'b0, 32'($urandom())};
        endcase
    endfunction

    // ------------------------------------------------------------------
    // main sequence: reset, directed plan, random phases, drain
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_event_result      expected;
        logic [EVENT_W-1:0] e;
        logic [TARGET_W-1:0] t;
        logic [RATE_W-1:0]  a;
        logic [RATE_W-1:0]  f;
        logic [RATE_W-1:0]  tw;
        logic [USERS_W-1:0] u;
        t_profile           profile;
        int                 drawn;
        int                 phase;
        int                 quota;

        clear_state();

        // rates 1.0 after reset, no users yet
        plan.push_back(known_row(EVENT_W'(1), '0, KIND_ADD, '0, 11'd1, ST_OK));
        // whole draw lands at the top of the tweet band, user past the end clamped
        plan.push_back(known_row(FULL_DRAW, '1, KIND_TWEET, '0, 11'd1, ST_OK));
        // draw above one behaves as exactly one
        plan.push_back(known_row('1, '0, KIND_TWEET, '0, 11'd1, ST_OK));
        // draw of zero falls in the add band
        plan.push_back(known_row('0, 32'h1234_5678, KIND_ADD, '0, 11'd2, ST_OK));
        plan.push_back(draw_row(33'h0_8000_0000, '1));
        plan.push_back(draw_row(33'h0_5555_5555, 32'h8000_0000));
        plan.push_back(draw_row(33'h0_AAAA_AAAA, 32'h0000_0001));
        // every weight zero: always add
        plan.push_back(settings_row('0, '0, '0, 11'd5));
        plan.push_back(known_row(FULL_DRAW, '1, KIND_ADD, '0, 11'd6, ST_OK));
        plan.push_back(known_row('0, '0, KIND_ADD, '0, 11'd7, ST_OK));
        // user table full
        plan.push_back(settings_row('1, '0, '0, 11'd1024));
        plan.push_back(known_row(EVENT_W'(1), '0, KIND_ADD, '0, 11'd1024, ST_USERS_FULL));
        plan.push_back(known_row(FULL_DRAW, '1, KIND_ADD, '0, 11'd1024, ST_USERS_FULL));
        // largest follow and tweet rates and users, last user charged with a tweet
        plan.push_back(settings_row('0, '1, '1, 11'd1024));
        plan.push_back(known_row(FULL_DRAW, '1, KIND_TWEET, 10'd1023, 11'd1024, ST_OK));
        plan.push_back(draw_row(EVENT_W'(1), '1));
        plan.push_back(draw_row(33'h0_4000_0000, 32'h8000_0000));
        plan.push_back(draw_row(33'h0_C000_0000, 32'h7FFF_FFFF));
        // smallest nonzero rates
        plan.push_back(settings_row(RATE_W'(1), RATE_W'(1), RATE_W'(1), 11'd1));
        plan.push_back(draw_row(FULL_DRAW, '1));
        plan.push_back(draw_row(33'h0_8000_0000, '1));
        plan.push_back(draw_row(33'h0_2000_0000, '0));
        plan.push_back(settings_row(RATE_RESET, RATE_RESET, RATE_RESET, '0));
        plan.push_back(draw_row(33'h0_FFFF_FFFF, 32'h0F0F_0F0F));

        // synchronous reset; the block then sweeps its list lengths
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].op == ROW_SETTINGS) begin
                load_settings(plan[i].add, plan[i].follow, plan[i].tweet, plan[i].users);
            end else begin
                offer_draw(plan[i].draw, plan[i].frac);
                expected = select_event(plan[i].draw, plan[i].frac);
                if (plan[i].typed) begin
                    expected.kind = plan[i].known.kind;
                    expected.actor = plan[i].known.actor;
                    expected.followed = plan[i].known.followed;
                    expected.slot = plan[i].known.slot;
                    expected.users = plan[i].known.users;
                    expected.status = plan[i].known.status;
                end
                pending.push_back(expected);
                pace_sender();
            end
        end

        // random phases, each behind a fresh register setting
        drawn = 0;
        phase = 0;
        while (drawn < RANDOM_ITEMS) begin
            if (phase == 1) profile = MIX_LIST_FILL;
            else if (phase == 3) profile = MIX_CROWDED;
            else profile = t_profile'($urandom_range(0, 2));
            case (profile)
                // few users, no adds and mostly follows: lists run full
                MIX_LIST_FILL: begin
                    a = '0;
                    f = RATE_W'($urandom_range(1, 24'hFF_FFFF));
                    tw = ($urandom_range(0, 1) == 0) ? '0 : RATE_W'($urandom_range(1, 255));
                    u = USERS_W'($urandom_range(1, 3));
                end
                // table at or near its limit
                MIX_CROWDED: begin
                    a = pick_rate();
                    f = pick_rate();
                    tw = pick_rate();
                    u = ($urandom_range(0, 1) == 0) ? USERS_W'(USER_LIMIT)
                                                    : USERS_W'($urandom_range(900, 1024));
                end
                default: begin
                    a = pick_rate();
                    f = pick_rate();
                    tw = pick_rate();
                    u = pick_users();
                end
            endcase
            load_settings(a, f, tw, u);
            quota = $urandom_range(80, 160);
            repeat (quota) begin
                e = random_draw();
                t = $urandom();
                offer_draw(e, t);
                pending.push_back(select_event(e, t));
                drawn++;
                pace_sender();
            end
            phase++;
        end

        // drain, then give the block a little longer to misbehave
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: stall pattern, long hold-off, compare with the oldest expectation
    // ------------------------------------------------------------------

    initial begin : result_side
        t_event_result exp_ev;
        t_event_result got;
        t_flow         flow;
        int            flow_left;
        int            hold_left;
        int            results_seen;
        logic          stall_next;
        flow = FLOW_FREE;
        flow_left = 0;
        hold_left = 0;
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.kind = t_kind'(o_event_kind);
                got.actor = o_acting_user;
                got.followed = o_followed_user;
                got.slot = o_list_slot;
                got.users = o_user_total;
                got.follows = o_follow_total;
                got.tweets = o_tweet_total;
                got.status = t_status'(o_status);
                if (pending.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("mismatch: result %0d arrived with nothing expected",
                                 results_seen);
                end else begin
                    exp_ev = pending.pop_front();
                    if (got.kind !== exp_ev.kind || got.actor !== exp_ev.actor ||
                        got.followed !== exp_ev.followed || got.slot !== exp_ev.slot ||
                        got.users !== exp_ev.users || got.follows !== exp_ev.follows ||
                        got.tweets !== exp_ev.tweets || got.status !== exp_ev.status) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS) begin
                            $display("mismatch: result %0d exp kind %0d actor %0d follow %0d",
                                     results_seen, exp_ev.kind, exp_ev.actor,
                                     exp_ev.followed,
                                     " slot %0d users %0d follows %0d tweets %0d status %0d",
                                     exp_ev.slot, exp_ev.users, exp_ev.follows,
                                     exp_ev.tweets, exp_ev.status);
                            $display("mismatch: result %0d got kind %0d actor %0d follow %0d",
                                     results_seen, got.kind, got.actor, got.followed,
                                     " slot %0d users %0d follows %0d tweets %0d status %0d",
                                     got.slot, got.users, got.follows, got.tweets,
                                     got.status);
                        end
                    end
                end
                results_seen++;
                // long hold-off now and then so the input backs up
                if (results_seen % 500 == 250) hold_left = HOLD_CYCLES;
            end

            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else begin
                if (flow_left == 0) begin
                    flow = t_flow'($urandom_range(0, 3));
                    flow_left = $urandom_range(20, 300);
                end
                flow_left--;
                case (flow)
                    FLOW_LIGHT:  stall_next = ($urandom_range(0, 3) == 0);
                    FLOW_HEAVY:  stall_next = ($urandom_range(0, 3) != 0);
                    FLOW_TOGGLE: stall_next = !i_out_stall;
                    default:     stall_next = 1'b0;
                endcase
            end
            i_out_stall <= stall_next;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction on any channel
    // ------------------------------------------------------------------

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

endmodule
